@@ rtl/pfd_pkg.sv @@
package pfd_pkg;

    // Frame framing and layout
    localparam logic [7:0] OPEN_BYTE  = 8'h7B;   // '{'
    localparam logic [7:0] CLOSE_BYTE = 8'h7D;   // '}'
    localparam int unsigned FRAME_LEN = 10;
    localparam int unsigned CODE_LEN  = 4;
    localparam int unsigned COUNT_W   = 4;
    localparam int unsigned PROV_W    = 5;

    // Province table
    localparam int unsigned TABLE_SIZE           = 26;
    localparam int unsigned PROVINCE_COUNT_DFLT  = 26;

    // Four ASCII hex characters per entry, first character in the top byte
    localparam logic [31:0] CODE_TABLE [0:TABLE_SIZE-1] = '{
        "5180", "664b", "8fbd", "5409", "9ed1", "82cf", "6d59", "7696",
        "95fd", "8d63", "9c81", "8c6b", "9102", "6e58", "7ca4", "743c",
        "5ddd", "8d35", "4e91", "9655", "7518", "9752", "8499", "6842",
        "5b81", "4eac"
    };

    // Lookup result handed from the code matcher to the top level
    typedef struct packed {
        logic              hit;
        logic [PROV_W-1:0] index;
    } pfd_lookup_t;

    // One result transaction, frame_ok in the lowest bit
    typedef struct packed {
        logic              confirmed;
        logic [7:0]        plate_char_5;
        logic [7:0]        plate_char_4;
        logic [7:0]        plate_char_3;
        logic [7:0]        plate_char_2;
        logic [7:0]        plate_char_1;
        logic [7:0]        plate_char_0;
        logic              code_matched;
        logic [PROV_W-1:0] province_index;
        logic              frame_ok;
    } pfd_result_t;

endpackage

@@ rtl/pfd_code_lookup.sv @@
module pfd_code_lookup #(
    parameter int unsigned PROVINCE_COUNT = pfd_pkg::PROVINCE_COUNT_DFLT
) (
    input  logic [31:0]          code,
    output pfd_pkg::pfd_lookup_t result
);
    import pfd_pkg::*;

    localparam int unsigned SEARCH_COUNT =
        (PROVINCE_COUNT < TABLE_SIZE) ? PROVINCE_COUNT : TABLE_SIZE;

    // Parallel compare against the constant table, lowest index wins
    always_comb
    begin
        result.hit   = 1'b0;
        result.index = PROV_W'(PROVINCE_COUNT);
        for (int i = 0; i < SEARCH_COUNT; i++)
        begin
            if (!result.hit && (code == CODE_TABLE[i]))
            begin
                result.hit   = 1'b1;
                result.index = PROV_W'(i);
            end
        end
    end

endmodule

@@ rtl/plate_frame_decoder.sv @@
// Channel   Dir  Width  Contents
// s_axis    in   8      tdata: rx_byte[7:0]
// m_axis    out  56     tdata: frame_ok, province_index[4:0], code_matched,
//                              plate_char_0..5 (8 each), confirmed
//
// A closing '}' loads its frame's result into the result register, or into the skid entry on a stall.
// One byte per cycle sustained while the skid entry is empty: the table match and counter update
// sit between the frame state registers and the result register.
// A two-entry output (result register plus skid) keeps s_axis_tready high while
// one result waits on a stalled m_axis.
// rst_n clears frame state, province tracking and output valids; payload bytes
// need no reset.
module plate_frame_decoder #(
    parameter int unsigned PROVINCE_COUNT = pfd_pkg::PROVINCE_COUNT_DFLT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // [0] frame_ok, [5:1] province_index,
                                        // [6] code_matched, [14:7] plate_char_0,
                                        // ... [54:47] plate_char_5, [55] confirmed
);
    import pfd_pkg::*;

    localparam logic [PROV_W-1:0] NONE_PROV = PROV_W'(PROVINCE_COUNT);

    // Frame and tracking state
    logic                in_frame_reg,  in_frame_next;
    logic [COUNT_W-1:0]  count_reg,     count_next;
    logic                zero_reg,      zero_next;
    logic [7:0]          payload_reg [FRAME_LEN];
    logic [PROV_W-1:0]   cur_prov_reg,  cur_prov_next;
    logic [PROV_W-1:0]   ref_prov_reg,  ref_prov_next;
    logic [1:0]          match_cnt_reg, match_cnt_next;

    // Output register and skid
    pfd_result_t         out_reg,       out_next;
    logic                out_vld_reg,   out_vld_next;
    pfd_result_t         skid_reg,      skid_next;
    logic                skid_vld_reg,  skid_vld_next;

    logic                accept;
    logic                payload_we;
    logic                res_fire;
    logic                frame_ok;
    pfd_lookup_t         lookup;
    pfd_result_t         res;

    assign s_axis_tready = !skid_vld_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Province code match on the first four payload bytes
    pfd_code_lookup #(
        .PROVINCE_COUNT (PROVINCE_COUNT)
    ) u_lookup (
        .code   ({payload_reg[0], payload_reg[1], payload_reg[2], payload_reg[3]}),
        .result (lookup)
    );

    assign frame_ok = (count_reg == COUNT_W'(FRAME_LEN)) && !zero_reg;

    // Frame parsing, province tracking and result assembly
    always_comb
    begin
        in_frame_next  = in_frame_reg;
        count_next     = count_reg;
        zero_next      = zero_reg;
        cur_prov_next  = cur_prov_reg;
        ref_prov_next  = ref_prov_reg;
        match_cnt_next = match_cnt_reg;
        payload_we     = 1'b0;
        res_fire       = 1'b0;

        res                = '0;
        res.frame_ok       = frame_ok;
        res.province_index = cur_prov_reg;

        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (s_axis_tdata == OPEN_BYTE)
                begin
                    in_frame_next = 1'b1;
                    count_next    = '0;
                    zero_next     = 1'b0;
                end
            end
            else if (s_axis_tdata != CLOSE_BYTE)
            begin
                if (count_reg < COUNT_W'(FRAME_LEN))
                begin
                    payload_we = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (s_axis_tdata == 8'h00)
                        zero_next = 1'b1;
                end
            end
            else
            begin
                in_frame_next = 1'b0;
                res_fire      = 1'b1;
                if (frame_ok)
                begin
                    if (lookup.hit)
                        cur_prov_next = lookup.index;
                    if (match_cnt_reg == 2'd0)
                    begin
                        ref_prov_next  = cur_prov_next;
                        match_cnt_next = 2'd1;
                    end
                    else if (cur_prov_next == ref_prov_reg)
                    begin
                        if (match_cnt_reg != 2'd3)
                            match_cnt_next = match_cnt_reg + 2'd1;
                        else
                            res.confirmed = 1'b1;
                    end
                    else
                    begin
                        match_cnt_next = 2'd0;
                    end
                    res.province_index = cur_prov_next;
                    res.code_matched   = lookup.hit;
                    res.plate_char_0   = payload_reg[4];
                    res.plate_char_1   = payload_reg[5];
                    res.plate_char_2   = payload_reg[6];
                    res.plate_char_3   = payload_reg[7];
                    res.plate_char_4   = payload_reg[8];
                    res.plate_char_5   = payload_reg[9];
                end
            end
        end
    end

    // Output register with skid entry
    always_comb
    begin
        out_next      = out_reg;
        out_vld_next  = out_vld_reg;
        skid_next     = skid_reg;
        skid_vld_next = skid_vld_reg;
        if (!out_vld_reg || m_axis_tready)
        begin
            if (skid_vld_reg)
            begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_next     = res;
                out_vld_next = res_fire;
            end
        end
        else if (res_fire)
        begin
            skid_next     = res;
            skid_vld_next = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg  <= 1'b0;
            count_reg     <= '0;
            zero_reg      <= 1'b0;
            cur_prov_reg  <= NONE_PROV;
            ref_prov_reg  <= NONE_PROV;
            match_cnt_reg <= 2'd0;
            out_vld_reg   <= 1'b0;
            skid_vld_reg  <= 1'b0;
        end
        else
        begin
            in_frame_reg  <= in_frame_next;
            count_reg     <= count_next;
            zero_reg      <= zero_next;
            cur_prov_reg  <= cur_prov_next;
            ref_prov_reg  <= ref_prov_next;
            match_cnt_reg <= match_cnt_next;
            out_vld_reg   <= out_vld_next;
            skid_vld_reg  <= skid_vld_next;
        end
    end

    // Payload bytes and result data
    always_ff @(posedge clk)
    begin
        if (payload_we)
            payload_reg[count_reg] <= s_axis_tdata;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

    // Checks
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry held while output register empty");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(FRAME_LEN))
        else $error("payload count past frame length");

    a_short_frame_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !out_reg.frame_ok) |->
            (!out_reg.code_matched && !out_reg.confirmed
             && out_reg.plate_char_0 == 8'h00 && out_reg.plate_char_5 == 8'h00))
        else $error("short frame result carries data");

    a_short_frame_keeps_track: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && !frame_ok) |=>
            (cur_prov_reg == $past(cur_prov_reg) && match_cnt_reg == $past(match_cnt_reg)))
        else $error("short frame changed province tracking");

    a_confirm_at_three: assert property (@(posedge clk) disable iff (!rst_n)
        (res_fire && res.confirmed) |-> (match_cnt_reg == 2'd3))
        else $error("confirmation without three prior matches");

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

    import pfd_pkg::*;

    localparam int SEARCH_N    = (PROVINCE_COUNT_DFLT < TABLE_SIZE) ?
                                 PROVINCE_COUNT_DFLT : TABLE_SIZE;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_AFTER  = 500;
    localparam int STIM_BYTES  = 1440;
    localparam int DRAIN       = 8;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    // Stimulus bytes waiting for the driver, decoded frames waiting for the DUT
    logic [7:0]  rx_bytes_q [$];
    pfd_result_t frame_reports_q [$];

    int err_count   = 0;
    int bytes_taken = 0;
    int idle_cycles = 0;

    // Decoder state mirror
    logic       in_frame_m;
    logic [3:0] count_m;
    logic       zero_m;
    logic [7:0] payload_m [FRAME_LEN];
    logic [4:0] cur_prov_m;
    logic [4:0] ref_prov_m;
    logic [1:0] run_m;

    plate_frame_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [55:0] got,
                                   input logic [55:0] want);
        $display("ERROR @%0t: %s: got %0h, want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // Index of the province whose code matches payload bytes 0-3, or -1
    function automatic int find_province();
        for (int i = 0; i < SEARCH_N; i++)
        begin
            if ({payload_m[0], payload_m[1], payload_m[2], payload_m[3]} == CODE_TABLE[i])
                return i;
        end
        return -1;
    endfunction

    // Advance the decoder mirror by one byte; returns 1 when a frame closes
    function automatic bit decode_byte(input logic [7:0] b, output pfd_result_t r);
        int   hit_idx;
        logic ok;
        r = '0;
        if (!in_frame_m)
        begin
            if (b == OPEN_BYTE)
            begin
                in_frame_m = 1'b1;
                count_m    = '0;
                zero_m     = 1'b0;
            end
            return 1'b0;
        end
        if (b != CLOSE_BYTE)
        begin
            if (count_m < FRAME_LEN)
            begin
                payload_m[count_m] = b;
                if (b == 8'h00)
                    zero_m = 1'b1;
                count_m++;
            end
            return 1'b0;
        end
        in_frame_m = 1'b0;
        ok = (count_m >= FRAME_LEN) && !zero_m;
        r.frame_ok = ok;
        if (ok)
        begin
            hit_idx = find_province();
            if (hit_idx >= 0)
            begin
                r.code_matched = 1'b1;
                cur_prov_m     = hit_idx[4:0];
            end
            // Same-province run tracking
            if (run_m == 2'd0)
            begin
                ref_prov_m = cur_prov_m;
                run_m      = 2'd1;
            end
            else if (cur_prov_m == ref_prov_m)
            begin
                if (run_m < 2'd3)
                    run_m++;
                else
                    r.confirmed = 1'b1;
            end
            else
                run_m = 2'd0;
            r.plate_char_0 = payload_m[4];
            r.plate_char_1 = payload_m[5];
            r.plate_char_2 = payload_m[6];
            r.plate_char_3 = payload_m[7];
            r.plate_char_4 = payload_m[8];
            r.plate_char_5 = payload_m[9];
        end
        r.province_index = cur_prov_m;
        return 1'b1;
    endfunction

    // Any byte that neither ends a frame nor shortens it
    function automatic logic [7:0] plate_byte();
        logic [7:0] v;
        do
            v = 8'($urandom_range(1, 255));
        while (v == CLOSE_BYTE);
        return v;
    endfunction

    function automatic logic [31:0] random_code();
        string hex_chars;
        logic [31:0] c;
        hex_chars = "0123456789abcdefABCDEF";
        for (int i = 0; i < 4; i++)
            c[31 - 8*i -: 8] = ($urandom_range(0, 1) == 0) ?
                               hex_chars[$urandom_range(0, 21)] : plate_byte();
        return c;
    endfunction

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            rx_bytes_q.push_back(s[i]);
    endtask

    // One framed record: code, tail bytes, optional zero at payload position
    task automatic add_frame(input logic [31:0] code, input int tail_len,
                             input int zero_pos);
        logic [7:0] b;
        rx_bytes_q.push_back(OPEN_BYTE);
        for (int i = 0; i < 4 + tail_len; i++)
        begin
            b = (i < 4) ? code[31 - 8*i -: 8] : plate_byte();
            if (i == zero_pos)
                b = 8'h00;
            rx_bytes_q.push_back(b);
        end
        rx_bytes_q.push_back(CLOSE_BYTE);
    endtask

    // Stimulus build, reset and end of run
    initial
    begin
        logic [31:0] last_code;
        int          sel;
        int          n;
        int          total_bytes;

        in_frame_m = 1'b0;
        count_m    = '0;
        zero_m     = 1'b0;
        cur_prov_m = 5'(PROVINCE_COUNT_DFLT);
        ref_prov_m = 5'(PROVINCE_COUNT_DFLT);
        run_m      = 2'd0;

        // Stray bytes outside any frame are ignored
        rx_bytes_q.push_back(8'h00);
        rx_bytes_q.push_back(8'hFF);
        rx_bytes_q.push_back(CLOSE_BYTE);
        // Open byte stored as payload, plate byte extremes
        push_text("{5180{");
        rx_bytes_q.push_back(8'h01);
        rx_bytes_q.push_back(8'hFF);
        push_text("Z9Q}");
        // Run up to and past confirmation
        repeat (4) add_frame("5180", 6, -1);
        add_frame("ABCD", 6, -1);           // unknown code keeps province
        add_frame("664B", 6, -1);           // case matters
        add_frame("4eac", 6, -1);           // new province clears the run
        push_text("{}");                    // empty frame
        add_frame("5180", 2, -1);           // short frame
        add_frame("9ed1", 6, 5);            // zero inside the plate
        add_frame("9ed1", 6, 0);            // zero as the first byte
        add_frame("7696", 9, -1);           // surplus bytes dropped
        add_frame("4eac", 6, -1);

        // Random part: mostly good frames sharing a province, some damage
        last_code = CODE_TABLE[0];
        while (rx_bytes_q.size() < STIM_BYTES)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 5)
            begin
                n = $urandom_range(1, 3);
                repeat (n) rx_bytes_q.push_back(8'($urandom_range(0, 255)));
            end
            else if (sel < 12)
                add_frame(last_code, $urandom_range(0, 5), -1);
            else if (sel < 17)
                add_frame(last_code, 6, $urandom_range(0, 9));
            else if (sel < 22)
                add_frame(last_code, $urandom_range(7, 12), -1);
            else if (sel < 30)
                add_frame(random_code(), 6, -1);
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    last_code = CODE_TABLE[$urandom_range(0, TABLE_SIZE - 1)];
                add_frame(last_code, 6, -1);
            end
        end
        total_bytes = rx_bytes_q.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Every byte taken by the DUT and every expected result seen
        while (bytes_taken < total_bytes || frame_reports_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);

        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Driver: bursts of bytes with random gaps
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left > 0)
            begin
                s_axis_tvalid <= 1'b0;
                gap_left      <= gap_left - 1;
            end
            else if (rx_bytes_q.size() > 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= rx_bytes_q.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: segments of steady, random or sparse ready, plus one long hold
    int  seg_mode  = 0;
    int  seg_left  = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (!hold_done && bytes_taken >= HOLD_AFTER)
        begin
            hold_left     <= HOLD_CYCLES;
            hold_done     <= 1'b1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (seg_left == 0)
            begin
                seg_mode <= $urandom_range(0, 2);
                seg_left <= $urandom_range(5, 60);
            end
            else
                seg_left <= seg_left - 1;
            case (seg_mode)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Monitor: check results first, then predict from the accepted byte
    pfd_result_t seen_result;
    pfd_result_t want_result;
    pfd_result_t next_result;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_result = m_axis_tdata;
                if (frame_reports_q.size() == 0)
                    report_mismatch("result with none expected", seen_result, '0);
                else
                begin
                    want_result = frame_reports_q.pop_front();
                    if (seen_result.frame_ok !== want_result.frame_ok)
                        report_mismatch("frame_ok", 56'(seen_result.frame_ok),
                                        56'(want_result.frame_ok));
                    if (seen_result.province_index !== want_result.province_index)
                        report_mismatch("province_index", 56'(seen_result.province_index),
                                        56'(want_result.province_index));
                    if (seen_result.code_matched !== want_result.code_matched)
                        report_mismatch("code_matched", 56'(seen_result.code_matched),
                                        56'(want_result.code_matched));
                    if (seen_result.plate_char_0 !== want_result.plate_char_0)
                        report_mismatch("plate_char_0", 56'(seen_result.plate_char_0),
                                        56'(want_result.plate_char_0));
                    if (seen_result.plate_char_1 !== want_result.plate_char_1)
                        report_mismatch("plate_char_1", 56'(seen_result.plate_char_1),
                                        56'(want_result.plate_char_1));
                    if (seen_result.plate_char_2 !== want_result.plate_char_2)
                        report_mismatch("plate_char_2", 56'(seen_result.plate_char_2),
                                        56'(want_result.plate_char_2));
                    if (seen_result.plate_char_3 !== want_result.plate_char_3)
                        report_mismatch("plate_char_3", 56'(seen_result.plate_char_3),
                                        56'(want_result.plate_char_3));
                    if (seen_result.plate_char_4 !== want_result.plate_char_4)
                        report_mismatch("plate_char_4", 56'(seen_result.plate_char_4),
                                        56'(want_result.plate_char_4));
                    if (seen_result.plate_char_5 !== want_result.plate_char_5)
                        report_mismatch("plate_char_5", 56'(seen_result.plate_char_5),
                                        56'(want_result.plate_char_5));
                    if (seen_result.confirmed !== want_result.confirmed)
                        report_mismatch("confirmed", 56'(seen_result.confirmed),
                                        56'(want_result.confirmed));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                bytes_taken <= bytes_taken + 1;
                if (decode_byte(s_axis_tdata, next_result))
                    frame_reports_q.push_back(next_result);
            end
        end
    end

    // Watchdog: too long with no transaction on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
